### design/etci_pkg.sv
package etci_pkg;

  localparam int FracBitsDef   = 26;
  localparam int CoordWidthDef = 32;
  localparam int CntW          = 16;
  localparam int AddrW         = 3;
  localparam int DataW         = 32;

  localparam logic [CntW-1:0] MaxIterRst = 16'd64;

  // Multiplier step selects for the two shared multipliers
  localparam logic [1:0] MUL_SQ     = 2'd0;  // re*re, im*im
  localparam logic [1:0] MUL_TRIPLE = 2'd1;  // 3re*im, 3re*re
  localparam logic [1:0] MUL_CUBE   = 2'd2;  // a2*re, b2*im
  localparam logic [1:0] MUL_CROSS  = 2'd3;  // s1*im, s2*im

  typedef struct packed {
    logic       load_start;
    logic       mul_en;
    logic [1:0] mul_op;
    logic       update;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic stop;     // outside the box or count at bound
    logic esc_mag;  // |z|^2 >= 4
    logic fixed;    // step left z unchanged
  } sts_t;

endpackage

### design/etci_ctrl.sv
module etci_ctrl
  import etci_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_M4   = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_op = MUL_SQ;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_start = 1'b1;
          state_d = S_M1;
        end
      end
      S_M1: begin
        if (sts_i.stop) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_op = MUL_SQ;
          state_d = S_M2;
        end
      end
      S_M2: begin
        if (sts_i.esc_mag) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_op = MUL_TRIPLE;
          state_d = S_M3;
        end
      end
      S_M3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_CUBE;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_CROSS;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d = sts_i.fixed ? S_DONE : S_M1;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/etci_datapath.sv
module etci_datapath
  import etci_pkg::*;
#(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk_i,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  input  logic signed [COORD_WIDTH-1:0] start_re_i,
  input  logic signed [COORD_WIDTH-1:0] start_im_i,
  input  logic        [CntW-1:0]        max_iter_i,
  output logic signed [COORD_WIDTH-1:0] final_re_o,
  output logic signed [COORD_WIDTH-1:0] final_im_o,
  output logic        [CntW-1:0]        iteration_count_o
);

  // Inside the escape box |re|,|im| < 2, so every term stays well inside DW bits
  localparam int MA = FRAC_BITS + 5;
  localparam int MB = FRAC_BITS + 2;
  localparam int PW = MA + MB;
  localparam int DW = FRAC_BITS + 7;
  localparam int EW = (COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH : FRAC_BITS + 3;
  localparam int SW = (COORD_WIDTH > DW) ? COORD_WIDTH + 1 : DW + 1;

  localparam logic signed [EW-1:0] TWO    = EW'(1) <<< (FRAC_BITS + 1);
  localparam logic signed [EW-1:0] NTWO   = -TWO;
  localparam logic signed [DW:0]   FOUR   = (DW + 1)'(1) <<< (FRAC_BITS + 2);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] CHI    = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] CLO    = -CHI - SW'(1);

  logic signed [COORD_WIDTH-1:0] re_q, im_q;
  logic signed [DW-1:0]          a2_q, b2_q, s1_q, s2_q, r3_q, i3_q, t_q, u_q;
  logic        [CntW-1:0]        cnt_q;
  logic signed [COORD_WIDTH-1:0] fre_q, fim_q;
  logic        [CntW-1:0]        fcnt_q;

  logic signed [EW-1:0] re_e, im_e;
  logic signed [MB-1:0] re_b, im_b;
  logic signed [MA-1:0] re_m, re3;
  logic signed [MA-1:0] ma0, ma1;
  logic signed [MB-1:0] mb0, mb1;
  logic signed [PW-1:0] prod0, prod1;
  logic signed [DW-1:0] q0, q1;
  logic signed [DW:0]   mag;
  logic signed [SW-1:0] nre_w, nim_w;
  logic signed [COORD_WIDTH-1:0] nre_s, nim_s;
  logic                 outside;

  assign re_e = EW'(re_q);
  assign im_e = EW'(im_q);
  assign re_b = re_e[MB-1:0];
  assign im_b = im_e[MB-1:0];
  assign re_m = MA'(re_b);
  assign re3  = re_m + (re_m <<< 1);

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_SQ: begin
        ma0 = re_m;            mb0 = re_b;
        ma1 = MA'(im_b);       mb1 = im_b;
      end
      MUL_TRIPLE: begin
        ma0 = re3;             mb0 = im_b;
        ma1 = re3;             mb1 = re_b;
      end
      MUL_CUBE: begin
        ma0 = a2_q[MA-1:0];    mb0 = re_b;
        ma1 = b2_q[MA-1:0];    mb1 = im_b;
      end
      MUL_CROSS: begin
        ma0 = s1_q[MA-1:0];    mb0 = im_b;
        ma1 = s2_q[MA-1:0];    mb1 = im_b;
      end
      default: begin
        ma0 = re_m;            mb0 = re_b;
        ma1 = MA'(im_b);       mb1 = im_b;
      end
    endcase
  end

  // Arithmetic shift of the exact product rounds toward minus infinity
  assign prod0 = PW'(ma0) * PW'(mb0);
  assign prod1 = PW'(ma1) * PW'(mb1);
  assign q0    = prod0[PW-1:FRAC_BITS];
  assign q1    = prod1[PW-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_op)
        MUL_SQ: begin
          a2_q <= q0;
          b2_q <= q1;
        end
        MUL_TRIPLE: begin
          s1_q <= q0;
          s2_q <= q1;
        end
        MUL_CUBE: begin
          r3_q <= q0;
          i3_q <= q1;
        end
        MUL_CROSS: begin
          t_q <= q0;
          u_q <= q1;
        end
        default: begin
          a2_q <= q0;
          b2_q <= q1;
        end
      endcase
    end
  end

  assign nre_w = SW'(re_q) - SW'(r3_q) + SW'(t_q) + ONE_S;
  assign nim_w = SW'(im_q) - SW'(u_q) + SW'(i3_q);

  always_comb begin
    priority if (nre_w > CHI) begin
      nre_s = CHI[COORD_WIDTH-1:0];
    end else if (nre_w < CLO) begin
      nre_s = CLO[COORD_WIDTH-1:0];
    end else begin
      nre_s = nre_w[COORD_WIDTH-1:0];
    end
    priority if (nim_w > CHI) begin
      nim_s = CHI[COORD_WIDTH-1:0];
    end else if (nim_w < CLO) begin
      nim_s = CLO[COORD_WIDTH-1:0];
    end else begin
      nim_s = nim_w[COORD_WIDTH-1:0];
    end
  end

  assign outside = (re_e >= TWO) || (re_e <= NTWO) || (im_e >= TWO) || (im_e <= NTWO);
  assign mag     = (DW + 1)'(a2_q) + (DW + 1)'(b2_q);

  assign sts_o.stop    = outside || (cnt_q >= max_iter_i);
  assign sts_o.esc_mag = (mag >= FOUR);
  assign sts_o.fixed   = (nre_s == re_q) && (nim_s == im_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      re_q  <= start_re_i;
      im_q  <= start_im_i;
      cnt_q <= '0;
    end else if (cmd_i.update) begin
      if (sts_o.fixed) begin
        cnt_q <= max_iter_i;
      end else begin
        re_q  <= nre_s;
        im_q  <= nim_s;
        cnt_q <= cnt_q + CntW'(1);
      end
    end
    if (cmd_i.load_out) begin
      fre_q  <= re_q;
      fim_q  <= im_q;
      fcnt_q <= cnt_q;
    end
  end

  assign final_re_o        = fre_q;
  assign final_im_o        = fim_q;
  assign iteration_count_o = fcnt_q;

endmodule

### design/escape_time_cubic_iteration.sv
// Per point: updates repeat from the accepted word until the bound or the escape box stops
//   the run (checked in S_M1), |z|^2 escapes (checked in S_M2) or an update hits a fixed
//   point; each update is four shared-multiplier steps plus an update state.
// Throughput: one point at a time, next word accepted in the cycle after the result is
//   loaded.
// Reset (rst_ni low, async): controller idle, no result pending, max_iterations = 64.
module escape_time_cubic_iteration
  import etci_pkg::*;
#(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_re_i,
  input  logic signed [COORD_WIDTH-1:0] start_im_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] final_re_o,
  output logic signed [COORD_WIDTH-1:0] final_im_o,
  output logic        [CntW-1:0]        iteration_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic        [AddrW-1:0]       paddr,
  input  logic        [DataW-1:0]       pwdata,
  output logic        [DataW-1:0]       prdata,
  output logic                          pready
);

  logic [CntW-1:0] max_iter_q, max_iter_d;
  logic            cfg_wr;
  cmd_t            cmd;
  sts_t            sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];

  assign max_iter_d = cfg_wr ? pwdata[CntW-1:0] : max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterRst;
    end else begin
      max_iter_q <= max_iter_d;
    end
  end

  assign prdata = paddr[2] ? '0 : DataW'(max_iter_q);

  etci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etci_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .start_re_i        (start_re_i),
    .start_im_i        (start_im_i),
    .max_iter_i        (max_iter_q),
    .final_re_o        (final_re_o),
    .final_im_o        (final_im_o),
    .iteration_count_o (iteration_count_o)
  );

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted but block not busy next cycle");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result loaded without valid");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_start, cmd.mul_en, cmd.update, cmd.load_out}))
    else $error("conflicting datapath commands");

  a_load_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_start |-> !in_stall_o && in_valid_i)
    else $error("start point loaded outside an accept");

endmodule
